FILE: rtl/best_fit_chunk_packer_top_macros.svh
// assertion macros for the chunk packer
`ifndef BEST_FIT_CHUNK_PACKER_TOP_MACROS_SVH
`define BEST_FIT_CHUNK_PACKER_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BFCP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bfcp_pkg.sv
// shared constants and types for the chunk packer
`timescale 1ns / 1ps
package bfcp_pkg;

  localparam int MAX_SLOTS    = 128;
  localparam int MAX_CAPACITY = 1024;

  localparam int SLOT_W  = 7;
  localparam int ROOM_W  = 10;
  localparam int CNT_W   = 8;
  localparam int LEN_W   = 11;
  localparam int TOTAL_W = 18;
  localparam int STAT_W  = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [STAT_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LEN = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED = 2'd3;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic CFG_NUM_SLOTS = 1'b0;
  localparam logic CFG_CAPACITY  = 1'b1;

  localparam logic [CNT_W-1:0]   NUM_SLOTS_RST = 8'd128;
  localparam logic [LEN_W-1:0]   CAPACITY_RST  = 11'd32;

  typedef struct packed {
    logic [SLOT_W-1:0] id;
    logic [ROOM_W-1:0] room;
  } plist_entry_t;

endpackage

FILE: rtl/best_fit_chunk_packer_top.sv
// best-fit chunk packer: top level with partial-list memory and scan sequencer
// clear or bad length go straight to S_RESP; a short chunk scans the partial list (S_SCAN per entry,
// S_SCAN_LAST, S_PICK) and on a fit passes S_MOVE; a full-length chunk, or a short one with no fit,
// takes S_FREE, which goes to S_RESP with no empty slot left; placements end in S_APPEND, then S_RESP;
// requests are taken only in S_IDLE, after the last result; a stalled out_tready holds the sequencer in S_RESP
// reset (rst_n low, synchronous): all slots empty, partial list empty, total zero,
// num_slots 128, slot_capacity 32; partial-list memory contents are not cleared
`timescale 1ns / 1ps
module best_fit_chunk_packer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfcp_pkg::IN_TDATA_W-1:0] in_tdata,   // [10:0] piece_length
  input  logic                            in_tuser,   // [0] opcode
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfcp_pkg::OUT_TDATA_W-1:0] out_tdata, // [6:0] slot_index,
                                                      // [17:7] room_left,
                                                      // [35:18] words_used
  output logic [bfcp_pkg::STAT_W-1:0]      out_tuser, // [1:0] status
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [bfcp_pkg::LEN_W-1:0]      cfg_data
);
  import bfcp_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;  // issue one partial-list read per cycle
  localparam logic [2:0] S_SCAN_LAST = 3'd2;  // compare the last entry read
  localparam logic [2:0] S_PICK      = 3'd3;  // best fit known, fetch tail entry
  localparam logic [2:0] S_MOVE      = 3'd4;  // tail entry fills the hole
  localparam logic [2:0] S_FREE      = 3'd5;  // pop an empty slot
  localparam logic [2:0] S_APPEND    = 3'd6;  // append leftover room, update total
  localparam logic [2:0] S_RESP      = 3'd7;  // hand result to the output register

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  num_slots_r, num_slots_nxt;
  logic [LEN_W-1:0]  capacity_r, capacity_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  pcount_r, pcount_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic              found_r, found_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [SLOT_W-1:0] best_i_r, best_i_nxt;
  logic [SLOT_W-1:0] best_id_r, best_id_nxt;
  logic [ROOM_W-1:0] best_room_r, best_room_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [LEN_W-1:0]  res_room_r, res_room_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0] out_user_r, out_user_nxt;

  // partial-list memory: slot id and room per entry
  plist_entry_t      plist_mem [MAX_SLOTS];
  plist_entry_t      rd_q_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  plist_entry_t      wr_data;

  // effective configuration, saturated to the supported range
  logic [LEN_W-1:0]  cap_use;
  logic [CNT_W-1:0]  slots_use;
  logic              in_acc;
  logic              out_free;
  logic              fits;
  logic              better;
  logic [TOTAL_W:0]  total_sum;
  logic [CNT_W-1:0]  pcount_dec;
  logic [CNT_W-1:0]  free_dec;

  assign cap_use   = (capacity_r > LEN_W'(MAX_CAPACITY)) ? LEN_W'(MAX_CAPACITY) : capacity_r;
  assign slots_use = (num_slots_r > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : num_slots_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_free   = !out_valid_r || out_tready;

  assign pcount_dec = pcount_r - CNT_W'(1);
  assign free_dec   = free_cnt_r - CNT_W'(1);

  // the compare unit: does this entry fit, and is it tighter than the best so far
  assign fits      = ({1'b0, rd_q_r.room} >= len_r);
  assign better    = !found_r || (rd_q_r.room < best_room_r);
  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(len_r);

  // memory read address: scan index, otherwise the tail entry
  assign rd_addr = (state_r == S_SCAN) ? idx_r : pcount_dec[SLOT_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_i_r;
    wr_data = rd_q_r;
    if (state_r == S_MOVE) begin
      wr_en = 1'b1;
    end else if (state_r == S_APPEND) begin
      wr_en        = (res_room_r != '0) && (pcount_r < CNT_W'(MAX_SLOTS));
      wr_addr      = pcount_r[SLOT_W-1:0];
      wr_data.id   = res_slot_r;
      wr_data.room = res_room_r[ROOM_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    num_slots_nxt = num_slots_r;
    capacity_nxt  = capacity_r;
    free_cnt_nxt  = free_cnt_r;
    pcount_nxt    = pcount_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    cmp_v_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = idx_r;
    best_i_nxt    = best_i_r;
    best_id_nxt   = best_id_r;
    best_room_nxt = best_room_r;
    res_slot_nxt  = res_slot_r;
    res_room_nxt  = res_room_r;
    res_stat_nxt  = res_stat_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    // configuration writes take effect at once
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_SLOTS: num_slots_nxt = cfg_data[CNT_W-1:0];
        CFG_CAPACITY:  capacity_nxt  = cfg_data;
        default:       ;
      endcase
    end

    // compare stage of the scan, one entry per cycle
    if (cmp_v_r && fits && better) begin
      found_nxt     = 1'b1;
      best_i_nxt    = cmp_idx_r;
      best_id_nxt   = rd_q_r.id;
      best_room_nxt = rd_q_r.room;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          len_nxt      = in_tdata[LEN_W-1:0];
          found_nxt    = 1'b0;
          idx_nxt      = '0;
          res_slot_nxt = '0;
          res_room_nxt = '0;
          if (in_tuser == OP_CLEAR) begin
            free_cnt_nxt = slots_use;
            pcount_nxt   = '0;
            total_nxt    = '0;
            res_stat_nxt = ST_CLEARED;
            state_nxt    = S_RESP;
          end else if (in_tdata[LEN_W-1:0] == '0 || in_tdata[LEN_W-1:0] > cap_use) begin
            res_stat_nxt = ST_BAD_LEN;
            state_nxt    = S_RESP;
          end else if (in_tdata[LEN_W-1:0] < cap_use && pcount_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FREE;
          end
        end
      end
      S_SCAN: begin
        cmp_v_nxt = 1'b1;
        idx_nxt   = idx_r + SLOT_W'(1);
        if ({1'b0, idx_r} == pcount_dec) begin
          state_nxt = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (found_r) begin
          // tail entry is read now, the list shrinks by one
          res_slot_nxt = best_id_r;
          res_room_nxt = {1'b0, best_room_r} - len_r;
          pcount_nxt   = pcount_dec;
          state_nxt    = S_MOVE;
        end else begin
          state_nxt = S_FREE;
        end
      end
      S_MOVE: begin
        state_nxt = S_APPEND;
      end
      S_FREE: begin
        // free stack always holds slot i at position i, so the top is count - 1
        if (free_cnt_r == '0) begin
          res_stat_nxt = ST_NO_ROOM;
          state_nxt    = S_RESP;
        end else begin
          free_cnt_nxt = free_dec;
          res_slot_nxt = free_dec[SLOT_W-1:0];
          res_room_nxt = cap_use - len_r;
          state_nxt    = S_APPEND;
        end
      end
      S_APPEND: begin
        if (wr_en) begin
          pcount_nxt = pcount_r + CNT_W'(1);
        end
        total_nxt    = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        res_stat_nxt = ST_PLACED;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_stat_r;
          out_data_nxt  = {(OUT_TDATA_W-TOTAL_W-LEN_W-SLOT_W)'(0), total_r,
                           res_room_r, res_slot_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_slots_r <= NUM_SLOTS_RST;
      capacity_r  <= CAPACITY_RST;
      free_cnt_r  <= NUM_SLOTS_RST;
      pcount_r    <= '0;
      total_r     <= '0;
      found_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_slots_r <= num_slots_nxt;
      capacity_r  <= capacity_nxt;
      free_cnt_r  <= free_cnt_nxt;
      pcount_r    <= pcount_nxt;
      total_r     <= total_nxt;
      found_r     <= found_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_i_r    <= best_i_nxt;
    best_id_r   <= best_id_nxt;
    best_room_r <= best_room_nxt;
    res_slot_r  <= res_slot_nxt;
    res_room_r  <= res_room_nxt;
    res_stat_r  <= res_stat_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  // partial-list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      plist_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= plist_mem[rd_addr];
  end

`include "best_fit_chunk_packer_top_macros.svh"

  `BFCP_ASSERT_ALWAYS(a_pcount_bound, pcount_r <= CNT_W'(MAX_SLOTS), "partial count overflow")
  `BFCP_ASSERT_ALWAYS(a_free_bound, free_cnt_r <= CNT_W'(MAX_SLOTS), "free count overflow")
  `BFCP_ASSERT_ALWAYS(a_scan_nonempty, (state_r != S_SCAN) || (pcount_r != '0), "scan on empty list")
  `BFCP_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE, "request not taken")

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the best-fit chunk packer
`timescale 1ns / 1ps
module testbench;
  import bfcp_pkg::*;

  typedef struct {
    logic             op;
    logic [LEN_W-1:0] len;
  } chunk_req_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   room;
    logic [TOTAL_W-1:0] words;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = OP_PLACE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_NUM_SLOTS;
  logic [LEN_W-1:0]       cfg_data = '0;

  always #4 clk = ~clk;

  best_fit_chunk_packer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the packer state
  logic [SLOT_W-1:0]  empty_slots [MAX_SLOTS];
  int                 empty_cnt;
  logic [SLOT_W-1:0]  part_ids [MAX_SLOTS];
  logic [ROOM_W-1:0]  part_room [MAX_SLOTS];
  int                 part_cnt;
  int unsigned        words_total;
  logic [CNT_W-1:0]   num_slots_reg;
  logic [LEN_W-1:0]   capacity_reg;

  chunk_req_t  pending_reqs [$];
  placement_t  placements_due [$];
  chunk_req_t  next_req;
  placement_t  got, want;
  int          n_issued = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  bit          gaps_off = 1'b0;

  // empty stack back to 0..n-1, partial list and total cleared
  function automatic void refill_slots();
    int n;
    n = (num_slots_reg > MAX_SLOTS) ? MAX_SLOTS : num_slots_reg;
    for (int i = 0; i < n; i++) empty_slots[i] = SLOT_W'(i);
    empty_cnt   = n;
    part_cnt    = 0;
    words_total = 0;
  endfunction

  // best-fit placement of one request, updates the shadow state
  function automatic placement_t pack_request(logic op, logic [LEN_W-1:0] len);
    placement_t r;
    int cap, best_i, best_room, slot, room;
    bit found;
    cap = (capacity_reg > MAX_CAPACITY) ? MAX_CAPACITY : capacity_reg;
    r.slot = '0;
    r.room = '0;
    if (op == OP_CLEAR) begin
      refill_slots();
      r.status = ST_CLEARED;
      r.words  = '0;
      return r;
    end
    r.words = TOTAL_W'(words_total);
    if (len == 0 || len > cap) begin
      r.status = ST_BAD_LEN;
      return r;
    end
    found = 1'b0;
    best_i = 0;
    best_room = 0;
    slot = 0;
    room = 0;
    // strict less-than keeps the first entry on equal room
    if (len < cap) begin
      for (int i = 0; i < part_cnt; i++) begin
        if (part_room[i] >= len && (!found || part_room[i] < best_room)) begin
          found = 1'b1;
          best_i = i;
          best_room = int'(part_room[i]);
        end
      end
      if (found) begin
        slot = int'(part_ids[best_i]);
        room = best_room;
        part_cnt--;
        part_ids[best_i]  = part_ids[part_cnt];
        part_room[best_i] = part_room[part_cnt];
      end
    end
    if (!found) begin
      if (empty_cnt == 0) begin
        r.status = ST_NO_ROOM;
        return r;
      end
      empty_cnt--;
      slot = int'(empty_slots[empty_cnt]);
      room = cap;
    end
    room -= len;
    if (room > 0 && part_cnt < MAX_SLOTS) begin
      part_ids[part_cnt]  = SLOT_W'(slot);
      part_room[part_cnt] = ROOM_W'(room);
      part_cnt++;
    end
    words_total += 32'(len);
    if (words_total > 262143) words_total = 262143;
    r.status = ST_PLACED;
    r.slot   = SLOT_W'(slot);
    r.room   = LEN_W'(room);
    r.words  = TOTAL_W'(words_total);
    return r;
  endfunction

  // request side, inputs change on the falling edge
  always @(negedge clk) begin
    out_tready <= gaps_off || ($urandom_range(99) >= 10);
    if (!in_tvalid || n_issued == n_accepted) begin
      if (pending_reqs.size() != 0 && (gaps_off || $urandom_range(99) >= 10)) begin
        next_req = pending_reqs.pop_front();
        in_tuser  <= next_req.op;
        in_tdata  <= IN_TDATA_W'(next_req.len);
        in_tvalid <= 1'b1;
        n_issued  <= n_issued + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // accepted requests feed the predictor, results are checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        placements_due = {placements_due, pack_request(in_tuser, in_tdata[LEN_W-1:0])};
        n_accepted <= n_accepted + 1;
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.slot   = out_tdata[6:0];
        got.room   = out_tdata[17:7];
        got.words  = out_tdata[35:18];
        status_seen[got.status]++;
        if (placements_due.size() == 0) begin
          if (n_errors < 10)
            $display("%0t: result with nothing expected: status %0d slot %0d room %0d",
                     $realtime, got.status, got.slot, got.room, " words %0d", got.words);
          n_errors++;
        end else begin
          want = placements_due.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.room !== want.room || got.words !== want.words) begin
            if (n_errors < 10) begin
              $display("%0t: mismatch: expected status %0d slot %0d room %0d words %0d",
                       $realtime, want.status, want.slot, want.room, want.words);
              $display("    got status %0d slot %0d room %0d words %0d",
                       got.status, got.slot, got.room, got.words);
            end
            n_errors++;
          end
        end
      end
    end
  end

  task automatic queue_req(logic op, int len);
    chunk_req_t q;
    q.op  = op;
    q.len = LEN_W'(len);
    pending_reqs = {pending_reqs, q};
  endtask

  // register write, only issued while the packer is idle
  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LEN_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUM_SLOTS) num_slots_reg = CNT_W'(value);
    else capacity_reg = LEN_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every request is taken and answered, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || n_issued != n_accepted || placements_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // mostly short chunks of random length, some full, bad and clear requests
  task automatic random_req(int cap);
    int pick, hi;
    pick = $urandom_range(99);
    if (pick < 3) begin
      queue_req(OP_CLEAR, $urandom_range(2047));
    end else if (pick < 8) begin
      if (cap >= 2047 || $urandom_range(1) == 0) queue_req(OP_PLACE, 0);
      else queue_req(OP_PLACE, $urandom_range(2047, cap + 1));
    end else if (pick < 20 || cap == 1) begin
      queue_req(OP_PLACE, cap);
    end else begin
      hi = cap / 4;
      if (hi < 1) hi = 1;
      if (hi > cap - 1) hi = cap - 1;
      if (pick < 60) queue_req(OP_PLACE, $urandom_range(hi, 1));
      else queue_req(OP_PLACE, $urandom_range(cap - 1, 1));
    end
  endtask

  int ns_set  [6] = '{128, 5, 128, 2, 64, 200};
  int cap_set [6] = '{32, 16, 1024, 1, 100, 7};

  initial begin
    int eff_cap;
    num_slots_reg = NUM_SLOTS_RST;
    capacity_reg  = CAPACITY_RST;
    refill_slots();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: bad lengths, full chunk, best fit, exact fit, tie on room
    queue_req(OP_PLACE, 0);
    queue_req(OP_PLACE, 33);
    queue_req(OP_PLACE, 2047);
    queue_req(OP_PLACE, 32);
    queue_req(OP_PLACE, 10);
    queue_req(OP_PLACE, 20);
    queue_req(OP_PLACE, 5);
    queue_req(OP_PLACE, 30);
    queue_req(OP_PLACE, 7);
    queue_req(OP_PLACE, 1);
    queue_req(OP_CLEAR, 1024);
    queue_req(OP_PLACE, 20);
    queue_req(OP_PLACE, 20);
    queue_req(OP_PLACE, 12);
    drain();

    // one slot of the largest capacity, then out of slots
    write_reg(CFG_NUM_SLOTS, 1);
    write_reg(CFG_CAPACITY, 1024);
    queue_req(OP_CLEAR, 0);
    queue_req(OP_PLACE, 1);
    queue_req(OP_PLACE, 1023);
    queue_req(OP_PLACE, 1);
    drain();

    // zero capacity makes every length bad; zero slots only after a clear
    write_reg(CFG_NUM_SLOTS, 0);
    write_reg(CFG_CAPACITY, 0);
    queue_req(OP_PLACE, 1);
    queue_req(OP_PLACE, 0);
    drain();
    write_reg(CFG_CAPACITY, 2047);
    queue_req(OP_PLACE, 1024);
    queue_req(OP_CLEAR, 0);
    queue_req(OP_PLACE, 5);
    drain();

    // slot count above the maximum saturates
    write_reg(CFG_NUM_SLOTS, 255);
    queue_req(OP_CLEAR, 0);
    queue_req(OP_PLACE, 1024);
    queue_req(OP_PLACE, 2047);
    drain();

    // random phases over several settings; the last changes registers without a clear
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_NUM_SLOTS, ns_set[p]);
      write_reg(CFG_CAPACITY, cap_set[p]);
      eff_cap = (cap_set[p] > MAX_CAPACITY) ? MAX_CAPACITY : cap_set[p];
      gaps_off = (p == 2);
      if (p != 5) queue_req(OP_CLEAR, 0);
      for (int i = 0; i < 165; i++) random_req(eff_cap);
      drain();
    end
    gaps_off = 1'b0;

    if (placements_due.size() != 0) n_errors++;
    $display("covered %0d requests over several register settings with random gaps on both sides",
             n_accepted);
    $display("results: %0d placed, %0d no room, %0d bad length, %0d cleared, %0d errors",
             status_seen[ST_PLACED], status_seen[ST_NO_ROOM], status_seen[ST_BAD_LEN],
             status_seen[ST_CLEARED], n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bfcp_pkg.sv
rtl/best_fit_chunk_packer_top.sv
dv/testbench.sv
